/* rtl/core/cbj0_pkg.sv */
// Package for the complex Bessel J0 series block: widths, constants, saturation helpers.
// No dependencies.
package cbj0_pkg;

    localparam int FracBits = 51;
    localparam int MaxTerms = 50;
    localparam int InW      = 56;
    localparam int DW       = 64;
    localparam int KW       = 6;
    localparam int DivW     = 12;

    localparam logic [DW-1:0] SMax = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] SMin = {1'b1, {(DW-1){1'b0}}};

    // multiplier operation codes
    typedef enum logic [1:0] {
        SH_FRAC  = 2'd0,
        SH_FRAC1 = 2'd1,
        SH_FRAC2 = 2'd2
    } mshift_t;

    // magnitude plus sign to saturated signed
    function automatic logic [DW-1:0] signed_sat(input logic [DW:0] m, input logic neg);
        logic [DW-1:0] r;
        if (neg)
        begin
            if (m >= {2'b01, {(DW-1){1'b0}}})
                r = SMin;
            else
                r = DW'(~m[DW-1:0] + 1'b1);
        end
        else
        begin
            if (m > {1'b0, SMax})
                r = SMax;
            else
                r = m[DW-1:0];
        end
        return r;
    endfunction

    function automatic logic [DW-1:0] sat_add(input logic [DW-1:0] a, input logic [DW-1:0] b);
        logic [DW:0] s;
        logic [DW-1:0] r;
        s = {a[DW-1], a} + {b[DW-1], b};
        if (s[DW] != s[DW-1])
            r = s[DW] ? SMin : SMax;
        else
            r = s[DW-1:0];
        return r;
    endfunction

    function automatic logic [DW-1:0] sat_sub(input logic [DW-1:0] a, input logic [DW-1:0] b);
        logic [DW:0] s;
        logic [DW-1:0] r;
        s = {a[DW-1], a} - {b[DW-1], b};
        if (s[DW] != s[DW-1])
            r = s[DW] ? SMin : SMax;
        else
            r = s[DW-1:0];
        return r;
    endfunction

    function automatic logic [DW-1:0] mag_of(input logic [DW-1:0] x);
        return x[DW-1] ? DW'(~x + 1'b1) : x;
    endfunction

endpackage

/* rtl/core/cbj0_mul.sv */
// Shared 64x64 magnitude multiplier, four 32x32 partial products accumulated in turn,
// then rounded shift and saturation. Depends on cbj0_pkg.
module cbj0_mul
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [cbj0_pkg::DW-1:0]   a,
    input  logic [cbj0_pkg::DW-1:0]   b,
    input  cbj0_pkg::mshift_t         sh_sel,
    output logic                      done,
    output logic [cbj0_pkg::DW-1:0]   p
);
    localparam int DW = cbj0_pkg::DW;

    logic [DW-1:0]   ua_reg, ub_reg;
    logic            neg_reg;
    cbj0_pkg::mshift_t sh_reg;
    logic [2*DW-1:0] acc_reg, acc_next;
    logic [2:0]      ph_reg;
    logic            busy_reg;
    logic [DW-1:0]   p_reg;
    logic            done_reg;
    logic [31:0]     op_a, op_b;
    logic [63:0]     pp;
    logic [2*DW-1:0] rnd;
    logic [DW:0]     res;

    always_comb
    begin
        op_a = ph_reg[1] ? ua_reg[63:32] : ua_reg[31:0];
        op_b = ph_reg[0] ? ub_reg[63:32] : ub_reg[31:0];
        pp   = 64'(op_a) * 64'(op_b);
        case (ph_reg[1:0])
            2'd0: acc_next = acc_reg + (2*DW)'(pp);
            2'd1: acc_next = acc_reg + ((2*DW)'(pp) << 32);
            2'd2: acc_next = acc_reg + ((2*DW)'(pp) << 32);
            default: acc_next = acc_reg + ((2*DW)'(pp) << 64);
        endcase
    end

    always_comb
    begin
        case (sh_reg)
            cbj0_pkg::SH_FRAC1:
            begin
                rnd = acc_reg + ((2*DW)'(1) << cbj0_pkg::FracBits);
                res = ((rnd >> (cbj0_pkg::FracBits + 1)) > (2*DW)'({1'b0, {DW{1'b1}}})) ?
                      {1'b1, {DW{1'b1}}} : (DW+1)'(rnd >> (cbj0_pkg::FracBits + 1));
            end
            cbj0_pkg::SH_FRAC2:
            begin
                rnd = acc_reg + ((2*DW)'(1) << (cbj0_pkg::FracBits + 1));
                res = ((rnd >> (cbj0_pkg::FracBits + 2)) > (2*DW)'({1'b0, {DW{1'b1}}})) ?
                      {1'b1, {DW{1'b1}}} : (DW+1)'(rnd >> (cbj0_pkg::FracBits + 2));
            end
            default:
            begin
                rnd = acc_reg + ((2*DW)'(1) << (cbj0_pkg::FracBits - 1));
                res = ((rnd >> cbj0_pkg::FracBits) > (2*DW)'({1'b0, {DW{1'b1}}})) ?
                      {1'b1, {DW{1'b1}}} : (DW+1)'(rnd >> cbj0_pkg::FracBits);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            ph_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                ph_reg   <= '0;
            end
            else if (busy_reg)
            begin
                if (ph_reg == 3'd4)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                ph_reg <= ph_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ua_reg  <= cbj0_pkg::mag_of(a);
            ub_reg  <= cbj0_pkg::mag_of(b);
            neg_reg <= a[DW-1] ^ b[DW-1];
            sh_reg  <= sh_sel;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (ph_reg[2])
                p_reg <= cbj0_pkg::signed_sat(res, neg_reg);
            else
                acc_reg <= acc_next;
        end
    end

    assign done = done_reg;
    assign p    = p_reg;
endmodule

/* rtl/core/cbj0_div.sv */
// Restoring divider, one quotient bit a cycle: round(-x / d), ties away from zero.
// Depends on cbj0_pkg.
module cbj0_div
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [cbj0_pkg::DW-1:0]     x,
    input  logic [cbj0_pkg::DivW-1:0]   d,
    output logic                        done,
    output logic [cbj0_pkg::DW-1:0]     q
);
    localparam int DW = cbj0_pkg::DW;
    localparam int DV = cbj0_pkg::DivW;

    logic [DW-1:0]   m_reg;
    logic [DW-1:0]   q_reg;
    logic [DV:0]     r_reg;
    logic [DV-1:0]   d_reg;
    logic            neg_reg;
    logic [6:0]      cnt_reg;
    logic            busy_reg;
    logic            done_reg;
    logic [DW-1:0]   out_reg;
    logic [DV+1:0]   trial;
    logic [DV:0]     r_sh;
    logic [DV+1:0]   twice;
    logic [DW:0]     qr;

    always_comb
    begin
        r_sh  = {r_reg[DV-1:0], m_reg[DW-1]};
        trial = {1'b0, r_sh} - {2'b00, d_reg};
        twice = {r_reg, 1'b0};
        qr    = (twice >= {2'b00, d_reg}) ? ({1'b0, q_reg} + 1'b1) : {1'b0, q_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == 7'(DW))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            m_reg   <= cbj0_pkg::mag_of(x);
            neg_reg <= ~x[DW-1];
            d_reg   <= (d == '0) ? DV'(1) : d;
            r_reg   <= '0;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 7'(DW))
                out_reg <= cbj0_pkg::signed_sat(qr, neg_reg);
            else
            begin
                m_reg <= {m_reg[DW-2:0], 1'b0};
                if (!trial[DV+1])
                begin
                    r_reg <= trial[DV:0];
                    q_reg <= {q_reg[DW-2:0], 1'b1};
                end
                else
                begin
                    r_reg <= r_sh;
                    q_reg <= {q_reg[DW-2:0], 1'b0};
                end
            end
        end
    end

    assign done = done_reg;
    assign q    = out_reg;
endmodule

/* rtl/core/complex_bessel_j0_series.sv */
// Top level of the complex Bessel J0 power series block: sequencer and registers.
// Depends on cbj0_pkg, cbj0_mul, cbj0_div.
//
//  channel | signals                         | dir
//  in      | in_valid, in_ready, z_re, z_im  | into block
//  out     | out_valid, out_ready, j0_re,    | out of block
//          | j0_im, range_error              |
//
// One argument at a time. Setup is three products on the shared multiplier;
// each series step takes four products plus two divides, for up to 49 steps
// (fewer when a term underflows, a single step when the first term does).
// Out of range arguments give their result the cycle after the input beat.
// Reset clears the sequencer.
// A result waits in the output register; the next argument is taken once it
// leaves.
module complex_bessel_j0_series
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [cbj0_pkg::InW-1:0] z_re,
    input  logic signed [cbj0_pkg::InW-1:0] z_im,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [cbj0_pkg::DW-1:0] j0_re,
    output logic signed [cbj0_pkg::DW-1:0] j0_im,
    output logic                          range_error
);
    localparam int DW = cbj0_pkg::DW;
    localparam logic [DW-1:0] One   = DW'(1) << cbj0_pkg::FracBits;
    localparam logic [DW-1:0] Limit = DW'(8) << cbj0_pkg::FracBits;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_W0   = 9'b000000010,
        S_W1   = 9'b000000100,
        S_W2   = 9'b000001000,
        S_P0   = 9'b000010000,
        S_P1   = 9'b000100000,
        S_P2   = 9'b001000000,
        S_P3   = 9'b010000000,
        S_DV   = 9'b100000000
    } state_t;

    state_t        state_reg;
    logic          wait_reg;      // waiting on a unit result
    logic          divim_reg;     // second divide of the step
    logic [DW-1:0] zr_reg, zi_reg, wr_reg, wi_reg, tr_reg, ti_reg, sr_reg, si_reg;
    logic [DW-1:0] a0_reg, pr_reg;
    logic [cbj0_pkg::KW-1:0] k_reg;
    logic          ov_reg;
    logic [DW-1:0] ore_reg, oim_reg;
    logic          oerr_reg;

    logic          m_start, m_done, d_start, d_done;
    logic [DW-1:0] m_a, m_b, m_p, d_x, d_q;
    cbj0_pkg::mshift_t m_sh;
    logic [DW-1:0] zr_ext, zi_ext;
    logic          accept;

    assign zr_ext  = DW'(z_re);
    assign zi_ext  = DW'(z_im);
    assign in_ready = (state_reg == S_IDLE) && !ov_reg;
    assign accept  = in_valid && in_ready;

    always_comb
    begin
        m_a  = tr_reg;
        m_b  = wr_reg;
        m_sh = cbj0_pkg::SH_FRAC;
        case (state_reg)
            S_W0: begin m_a = zr_reg; m_b = zr_reg; m_sh = cbj0_pkg::SH_FRAC2; end
            S_W1: begin m_a = zi_reg; m_b = zi_reg; m_sh = cbj0_pkg::SH_FRAC2; end
            S_W2: begin m_a = zr_reg; m_b = zi_reg; m_sh = cbj0_pkg::SH_FRAC1; end
            S_P0: begin m_a = tr_reg; m_b = wr_reg; end
            S_P1: begin m_a = ti_reg; m_b = wi_reg; end
            S_P2: begin m_a = tr_reg; m_b = wi_reg; end
            S_P3: begin m_a = ti_reg; m_b = wr_reg; end
            default: begin m_a = tr_reg; m_b = wr_reg; end
        endcase
        m_start = !wait_reg && (state_reg != S_IDLE) && (state_reg != S_DV);
        d_start = !wait_reg && (state_reg == S_DV);
        d_x     = divim_reg ? a0_reg : pr_reg;
    end

    cbj0_mul u_mul
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (m_start),
        .a      (m_a),
        .b      (m_b),
        .sh_sel (m_sh),
        .done   (m_done),
        .p      (m_p)
    );

    cbj0_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (d_start),
        .x     (d_x),
        .d     (cbj0_pkg::DivW'(k_reg) * cbj0_pkg::DivW'(k_reg)),
        .done  (d_done),
        .q     (d_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            wait_reg  <= 1'b0;
            divim_reg <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
                ov_reg <= 1'b0;
            if (m_start || d_start)
                wait_reg <= 1'b1;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (cbj0_pkg::mag_of(zr_ext) > Limit ||
                            cbj0_pkg::mag_of(zi_ext) > Limit)
                            ov_reg <= 1'b1;
                        else
                            state_reg <= S_W0;
                    end
                end
                S_W0: if (m_done) begin wait_reg <= 1'b0; state_reg <= S_W1; end
                S_W1: if (m_done) begin wait_reg <= 1'b0; state_reg <= S_W2; end
                S_W2: if (m_done) begin wait_reg <= 1'b0; state_reg <= S_P0; end
                S_P0: if (m_done) begin wait_reg <= 1'b0; state_reg <= S_P1; end
                S_P1: if (m_done) begin wait_reg <= 1'b0; state_reg <= S_P2; end
                S_P2: if (m_done) begin wait_reg <= 1'b0; state_reg <= S_P3; end
                S_P3: if (m_done) begin wait_reg <= 1'b0; state_reg <= S_DV; end
                S_DV:
                begin
                    if (d_done)
                    begin
                        wait_reg <= 1'b0;
                        if (!divim_reg)
                            divim_reg <= 1'b1;
                        else
                        begin
                            divim_reg <= 1'b0;
                            // stop on term underflow or step limit
                            if ((pr_reg == '0 && d_q == '0) ||
                                k_reg == cbj0_pkg::KW'(cbj0_pkg::MaxTerms - 1))
                            begin
                                state_reg <= S_IDLE;
                                ov_reg    <= 1'b1;
                            end
                            else
                                state_reg <= S_P0;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath; pr_reg holds the real quotient after the first divide
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    zr_reg   <= zr_ext;
                    zi_reg   <= zi_ext;
                    tr_reg   <= One;
                    ti_reg   <= '0;
                    sr_reg   <= One;
                    si_reg   <= '0;
                    k_reg    <= cbj0_pkg::KW'(1);
                    ore_reg  <= '0;
                    oim_reg  <= '0;
                    oerr_reg <= 1'b1;
                end
            end
            S_W0: if (m_done) wr_reg <= m_p;
            S_W1: if (m_done) wr_reg <= cbj0_pkg::sat_sub(wr_reg, m_p);
            S_W2: if (m_done) wi_reg <= m_p;
            S_P0: if (m_done) a0_reg <= m_p;
            S_P1: if (m_done) pr_reg <= cbj0_pkg::sat_sub(a0_reg, m_p);
            S_P2: if (m_done) a0_reg <= m_p;
            S_P3: if (m_done) a0_reg <= cbj0_pkg::sat_add(a0_reg, m_p);
            S_DV:
            begin
                if (d_done)
                begin
                    if (!divim_reg)
                        pr_reg <= d_q;
                    else
                    begin
                        tr_reg <= pr_reg;
                        ti_reg <= d_q;
                        k_reg  <= k_reg + cbj0_pkg::KW'(1);
                        if (pr_reg == '0 && d_q == '0)
                        begin
                            ore_reg  <= sr_reg;
                            oim_reg  <= si_reg;
                            oerr_reg <= 1'b0;
                        end
                        else
                        begin
                            sr_reg   <= cbj0_pkg::sat_add(sr_reg, pr_reg);
                            si_reg   <= cbj0_pkg::sat_add(si_reg, d_q);
                            ore_reg  <= cbj0_pkg::sat_add(sr_reg, pr_reg);
                            oim_reg  <= cbj0_pkg::sat_add(si_reg, d_q);
                            oerr_reg <= 1'b0;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    assign out_valid   = ov_reg;
    assign j0_re       = ore_reg;
    assign j0_im       = oim_reg;
    assign range_error = oerr_reg;
endmodule

/* verif/tb.sv */
// Testbench for complex_bessel_j0_series: random and directed complex arguments,
// with results checked against a fixed-point J0 series predictor. Depends on cbj0_pkg.
`timescale 1ns / 100ps

module tb;

    localparam int           FracBits   = cbj0_pkg::FracBits;
    localparam int           MaxTerms   = cbj0_pkg::MaxTerms;
    localparam int           InW        = cbj0_pkg::InW;
    localparam int           DW         = cbj0_pkg::DW;

    localparam int           NumRandom  = 1790;
    localparam int           QuietTail  = 200;   // final beats run with no idling
    localparam int           StallLimit = 40000; // watchdog bound, above the longest item
    localparam int           DrainWait  = 50;
    localparam logic [63:0]  ZLimit     = 64'd8 << FracBits;

    typedef struct {
        logic [63:0] re;
        logic [63:0] im;
        logic        err;
    } j0_result_t;

    typedef struct {
        logic [InW-1:0] re;
        logic [InW-1:0] im;
    } z_arg_t;

    // Scoreboard: predicts J0(z) for each accepted argument and checks results in order.
    class j0_scoreboard;
        j0_result_t pending_j0[$];
        int         mismatches = 0;

        function automatic logic [63:0] clamp_signed(logic [63:0] m, logic neg);
            if (neg)
            begin
                if (m >= 64'h8000_0000_0000_0000)
                    return 64'h8000_0000_0000_0000;
                return ~m + 64'd1;
            end
            if (m > 64'h7FFF_FFFF_FFFF_FFFF)
                return 64'h7FFF_FFFF_FFFF_FFFF;
            return m;
        endfunction

        function automatic logic [63:0] abs64(logic [63:0] x);
            return x[63] ? ~x + 64'd1 : x;
        endfunction

        function automatic logic [63:0] add_clip(logic [63:0] a, logic [63:0] b);
            logic [64:0] s;
            s = {a[63], a} + {b[63], b};
            if (s[64] != s[63])
                return s[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
            return s[63:0];
        endfunction

        function automatic logic [63:0] sub_clip(logic [63:0] a, logic [63:0] b);
            logic [64:0] s;
            s = {a[63], a} - {b[63], b};
            if (s[64] != s[63])
                return s[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
            return s[63:0];
        endfunction

        // (a*b) >> sh, round half away from zero, saturate
        function automatic logic [63:0] fx_mul(logic [63:0] a, logic [63:0] b, int sh);
            logic [127:0] p;
            logic         neg;
            neg = a[63] ^ b[63];
            p = {64'd0, abs64(a)} * {64'd0, abs64(b)};
            p = (p + (128'd1 << (sh - 1))) >> sh;
            if (p[127:64] != 0)
                return clamp_signed(64'hFFFF_FFFF_FFFF_FFFF, neg);
            return clamp_signed(p[63:0], neg);
        endfunction

        // -x / d, round half away from zero
        function automatic logic [63:0] neg_div(logic [63:0] x, logic [63:0] d);
            logic [63:0] m, q, r;
            m = abs64(x);
            q = m / d;
            r = m % d;
            if (r >= d - r)
                q = q + 64'd1;
            return clamp_signed(q, ~x[63]);
        endfunction

        function automatic j0_result_t bessel_j0(logic [InW-1:0] zr_in, logic [InW-1:0] zi_in);
            j0_result_t  res;
            logic [63:0] zr, zi, wr, wi, tr, ti, sr, si, pr, pi, d;
            zr = {{(64-InW){zr_in[InW-1]}}, zr_in};
            zi = {{(64-InW){zi_in[InW-1]}}, zi_in};
            if (abs64(zr) > ZLimit || abs64(zi) > ZLimit)
            begin
                res.re = 0;
                res.im = 0;
                res.err = 1'b1;
                return res;
            end
            // w = z*z/4
            wr = sub_clip(fx_mul(zr, zr, FracBits + 2), fx_mul(zi, zi, FracBits + 2));
            wi = fx_mul(zr, zi, FracBits + 1);
            tr = 64'd1 << FracBits;
            ti = 0;
            sr = tr;
            si = 0;
            for (int k = 1; k < MaxTerms; k++)
            begin
                pr = sub_clip(fx_mul(tr, wr, FracBits), fx_mul(ti, wi, FracBits));
                pi = add_clip(fx_mul(tr, wi, FracBits), fx_mul(ti, wr, FracBits));
                d  = 64'(k * k);
                tr = neg_div(pr, d);
                ti = neg_div(pi, d);
                if (tr == 0 && ti == 0)
                    break;
                sr = add_clip(sr, tr);
                si = add_clip(si, ti);
            end
            res.re = sr;
            res.im = si;
            res.err = 1'b0;
            return res;
        endfunction

        function void note_argument(logic [InW-1:0] zr, logic [InW-1:0] zi);
            pending_j0.push_back(bessel_j0(zr, zi));
        endfunction

        function void check_result(logic [63:0] re, logic [63:0] im, logic err);
            j0_result_t e;
            if (pending_j0.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: re=%h im=%h err=%b", re, im, err);
                return;
            end
            e = pending_j0.pop_front();
            if (e.re !== re || e.im !== im || e.err !== err)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp re=%h im=%h err=%b, got re=%h im=%h err=%b",
                             e.re, e.im, e.err, re, im, err);
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic signed [InW-1:0] z_re = '0;
    logic signed [InW-1:0] z_im = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic signed [DW-1:0]  j0_re;
    logic signed [DW-1:0]  j0_im;
    logic                  range_error;

    j0_scoreboard sb = new();
    z_arg_t       arg_list[$];
    bit           quiet = 1'b0;   // no idling in the tail of the run
    int           idle_cycles = 0;

    always #1 clk = ~clk;

    complex_bessel_j0_series dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .z_re        (z_re),
        .z_im        (z_im),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .j0_re       (j0_re),
        .j0_im       (j0_im),
        .range_error (range_error)
    );

    // Random argument part. Small magnitudes keep the series short; a slice
    // covers the full range and the raw 56-bit space (out of range included).
    function automatic logic [InW-1:0] rand_part();
        logic [63:0] m;
        int          sel;
        sel = $urandom_range(0, 99);
        m = {$urandom, $urandom};
        if (sel < 10)
            return InW'(m);                                  // raw bits, any range
        if (sel < 20)
            m = m % (ZLimit + 1);                            // full supported range
        else
            m = (m & ((64'd1 << 54) - 1)) >> $urandom_range(4, 54);  // small, log spread
        return $urandom_range(0, 1) ? InW'(~m + 64'd1) : InW'(m);
    endfunction

    function automatic void add_arg(logic [InW-1:0] re, logic [InW-1:0] im);
        z_arg_t a;
        a.re = re;
        a.im = im;
        arg_list.push_back(a);
    endfunction

    // Drives every queued argument; valid stays high across back-to-back beats.
    task automatic drive_args();
        int gap;
        for (int i = 0; i < arg_list.size(); i++)
        begin
            quiet = (i >= arg_list.size() - QuietTail);
            z_re     <= arg_list[i].re;
            z_im     <= arg_list[i].im;
            in_valid <= 1'b1;
            do
                @(posedge clk);
            while (!in_ready);
            sb.note_argument(arg_list[i].re, arg_list[i].im);
            gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
            if (gap > 0 || i == arg_list.size() - 1)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Result side: check each beat, then decide the next ready level.
    int stall_left = 0;
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(j0_re, j0_im, range_error);
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (!quiet && rst_n && $urandom_range(0, 3) == 0)
        begin
            stall_left = $urandom_range(0, 2);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // Watchdog on cycles with no beat on either channel.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= StallLimit)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        // directed: zero, the range edges, just past them, raw extremes, axes
        add_arg('0, '0);
        add_arg(InW'(ZLimit), InW'(ZLimit));
        add_arg(InW'(-ZLimit), InW'(-ZLimit));
        add_arg(InW'(ZLimit), InW'(-ZLimit));
        add_arg(InW'(ZLimit + 1), '0);
        add_arg('0, InW'(-ZLimit - 1));
        add_arg({1'b0, {(InW-1){1'b1}}}, {1'b1, {(InW-1){1'b0}}});
        add_arg({1'b1, {(InW-1){1'b0}}}, '0);
        add_arg(InW'(64'd1 << FracBits), '0);
        add_arg('0, InW'(64'd1 << FracBits));
        add_arg(InW'(64'd5 << FracBits), InW'(64'd3 << FracBits));
        add_arg(InW'(1), InW'(-1));        // terms underflow at once
        add_arg(InW'(64'd1 << 20), '0);
        for (int i = 0; i < NumRandom; i++)
            add_arg(rand_part(), rand_part());

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        drive_args();

        while (sb.pending_j0.size() != 0)
            @(posedge clk);
        repeat (DrainWait) @(posedge clk);
        if (sb.mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
